/* design/wcf_pkg.sv */
// ----------------------------------------------------------------------------
// wcf_pkg
// Shared types, codes and fixed-point helpers of the per-site Fst estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package wcf_pkg;

  // accumulator and field widths
  localparam int DOS_W      = 27;
  localparam int HET_W      = 26;
  localparam int CNT_W      = 11;
  localparam int ENT_DOS_W  = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // divider operand widths
  localparam int NUM_W = 64;
  localparam int DEN_W = 40;

  // missing-genotype code, 0.333333 in Q1.15
  localparam logic [15:0] NA_CODE = 16'd10923;

  localparam logic signed [63:0] ONE_Q24  = 64'sd16777216;
  localparam logic signed [63:0] FREQ_MAX = 64'sd67108864;
  localparam logic signed [63:0] SAT_MAX  = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] SAT_MIN  = 64'shffff_ffff_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POP_COUNT   = 2'd0,
    CFG_MIN_PER_POP = 2'd1,
    CFG_MIN_MAF     = 2'd2
  } wcf_cfg_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_LOW_POP = 2'd1,
    STAT_LOW_MAF = 2'd2,
    STAT_DEGEN   = 2'd3
  } wcf_status_e;

  typedef struct packed {
    logic [15:0] prob_ref;
    logic [15:0] prob_het;
    logic [15:0] prob_alt;
    logic [3:0]  pop_index;
    logic        last_individual;
  } wcf_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] within_component;
    logic signed [31:0] total_component;
    logic signed [31:0] fst_value;
  } wcf_out_t;

  // classified individual passed from front to back
  typedef struct packed {
    logic                 acc;
    logic                 last;
    logic [3:0]           pop;
    logic [ENT_DOS_W-1:0] dos;
    logic [15:0]          het;
  } wcf_entry_t;

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > SAT_MAX) return 32'sh7fff_ffff;
    else if (v < SAT_MIN) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  // clamp a frequency to [0, 4.0] in Q.24
  function automatic logic signed [31:0] clamp_freq(input logic signed [63:0] v);
    if (v < 64'sd0) return 32'sd0;
    else if (v > FREQ_MAX) return FREQ_MAX[31:0];
    else return v[31:0];
  endfunction

  // divide by 2^24, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd24(input logic signed [63:0] v);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + 64'd8388608) >> 24;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

`default_nettype wire

/* design/wcf_div.sv */
// ----------------------------------------------------------------------------
// wcf_div
// Shared rounded signed divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wcf_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [wcf_pkg::NUM_W-1:0]    num_i,
  input  wire logic signed [wcf_pkg::DEN_W-1:0]    den_i,
  output logic                                     done_o,
  output logic signed [wcf_pkg::NUM_W-1:0]         quo_o
);
  import wcf_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic              busy_q, done_q, neg_q, zero_q;
  logic [CW-1:0]     cnt_q;
  logic [DEN_W-1:0]  dmag_q;
  logic [DEN_W-1:0]  rem_q;
  logic [NUM_W-1:0]  quo_q;
  logic [NUM_W-1:0]  nmag;
  logic [DEN_W-1:0]  dmag;
  logic [DEN_W:0]    trial;
  logic              fits;

  // operand magnitudes and restoring step
  assign nmag  = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign dmag  = den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      zero_q <= 1'b0;
      cnt_q  <= '0;
      dmag_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        // bias by half the divisor for rounding
        quo_q  <= nmag + NUM_W'(dmag >> 1);
        rem_q  <= '0;
        dmag_q <= dmag;
        neg_q  <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
        zero_q <= (den_i == '0);
        cnt_q  <= CW'(NUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? DEN_W'(trial - {1'b0, dmag_q}) : DEN_W'(trial);
        quo_q <= {quo_q[NUM_W-2:0], fits};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) busy_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = zero_q ? '0 : (neg_q ? -$signed(quo_q) : $signed(quo_q));

endmodule

`default_nettype wire

/* design/wcf_front.sv */
// ----------------------------------------------------------------------------
// wcf_front
// Takes individuals, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wcf_front #(
  parameter int MAX_POPS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire wcf_pkg::wcf_in_t                  item_i,
  input  wire logic [$clog2(MAX_POPS+1)-1:0]     eff_pops_i,
  output logic                                   q_valid_o,
  output wcf_pkg::wcf_entry_t                    q_entry_o,
  input  wire logic                              q_pop_i
);
  import wcf_pkg::*;

  wcf_entry_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop, missing;
  wcf_entry_t ent;

  // classify the request
  assign missing = (item_i.prob_ref == NA_CODE) && (item_i.prob_het == NA_CODE) &&
                   (item_i.prob_alt == NA_CODE);
  always_comb begin
    ent.acc  = !missing && (32'(item_i.pop_index) < 32'(eff_pops_i));
    ent.last = item_i.last_individual;
    ent.pop  = item_i.pop_index;
    ent.dos  = ENT_DOS_W'(item_i.prob_het) + ENT_DOS_W'({item_i.prob_alt, 1'b0});
    ent.het  = item_i.prob_het;
  end

  assign busy      = (cnt_q == 2'd2);
  assign push      = start && !busy;
  assign pop       = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_entry_o = entry_q[rd_ptr_q];

  // two-entry queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        entry_q[wr_ptr_q] <= ent;
        wr_ptr_q          <= !wr_ptr_q;
      end
      if (pop) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

`default_nettype wire

/* design/wcf_back.sv */
// ----------------------------------------------------------------------------
// wcf_back
// Accumulates individuals per population and runs the per-site finish.
// ----------------------------------------------------------------------------
`default_nettype none

module wcf_back #(
  parameter int MAX_POPS        = 16,
  parameter int MAX_INDIVIDUALS = 1024
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [$clog2(MAX_POPS+1)-1:0]         eff_pops_i,
  input  wire logic [wcf_pkg::CNT_W-1:0]             min_per_pop_i,
  input  wire logic [wcf_pkg::CFG_DATA_W-1:0]        min_maf_i,
  input  wire logic                                  q_valid_i,
  input  wire wcf_pkg::wcf_entry_t                   q_entry_i,
  output logic                                       q_pop_o,
  output logic                                       res_valid_o,
  output wcf_pkg::wcf_out_t                          res_o
);
  import wcf_pkg::*;

  localparam int IW  = $clog2(MAX_POPS);
  localparam int RW  = $clog2(MAX_POPS + 1);
  localparam int SSW = 2 * CNT_W + RW;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_CLS, S_PREP, S_DIV, S_POST, S_SQ, S_TACC,
    S_PQ, S_A, S_A2, S_TOT, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    K_PB, K_HB, K_PI, K_S2, K_RS, K_X, K_Q, K_Y, K_B, K_F
  } step_e;

  state_e      state_q;
  step_e       step_q;
  wcf_status_e stat_q;

  logic [DOS_W-1:0] pop_dos_q [MAX_POPS];
  logic [CNT_W-1:0] pop_cnt_q [MAX_POPS];
  logic [DOS_W-1:0] tot_dos_q;
  logic [HET_W-1:0] tot_het_q;
  logic [CNT_W-1:0] tot_cnt_q;

  logic [IW-1:0]           idx_q;
  logic                    low_q, zero_q;
  logic [SSW-1:0]          s2sum_q;
  logic [2*CNT_W-1:0]      nn_q;
  logic signed [NUM_W-1:0] num_q;
  logic signed [DEN_W-1:0] den_q;
  logic                    div_go_q;
  logic signed [31:0]      pb_q, hb_q, s2_q, pq_q, rs_q, x_q, inner_q, qf_q;
  logic signed [31:0]      as_q, y_q, tot_q, fst_q;
  logic signed [27:0]      d_q;
  logic [55:0]             dd_q;
  logic [47:0]             t_q;
  logic signed [63:0]      ap_q, b_q;
  logic                    res_valid_q;
  wcf_out_t                res_q;

  logic [IW-1:0]           rd_addr;
  logic [DOS_W-1:0]        dos_rd;
  logic [CNT_W-1:0]        n_rd;
  logic [2*CNT_W-1:0]      n_sq, nn;
  logic                    acc_ok, last_idx, maf_fail, degen;
  logic [RW-1:0]           eff_m1;
  logic [11:0]             two_n;
  logic [26:0]             lim, hi;
  logic [32:0]             rdd;
  logic signed [63:0]      n_s, r_s, rm1_s, nn_s, ss_s, tot_w;
  logic                    div_done;
  logic signed [NUM_W-1:0] quo;

  // shared divider
  wcf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // single read address into the population arrays
  assign rd_addr = (state_q == S_IDLE) ? IW'(q_entry_i.pop) : idx_q;
  assign dos_rd  = pop_dos_q[rd_addr];
  assign n_rd    = pop_cnt_q[rd_addr];
  assign n_sq    = n_rd * n_rd;
  assign nn      = tot_cnt_q * tot_cnt_q;

  assign q_pop_o  = q_valid_i && (state_q == S_IDLE);
  assign acc_ok   = q_entry_i.acc && (32'(tot_cnt_q) < 32'(MAX_INDIVIDUALS));
  assign eff_m1   = eff_pops_i - RW'(1);
  assign last_idx = (RW'(idx_q) == eff_m1);

  // site filters
  assign two_n    = {tot_cnt_q, 1'b0};
  assign lim      = 27'(two_n * min_maf_i);
  assign hi       = {two_n, 15'b0};
  assign maf_fail = (tot_dos_q < lim) ||
                    ($signed({1'b0, hi}) - $signed({1'b0, tot_dos_q}) < $signed({1'b0, lim}));
  assign degen    = zero_q || (CNT_W'(eff_pops_i) == tot_cnt_q) || (SSW'(nn) == s2sum_q);

  assign n_s   = $signed(64'(tot_cnt_q));
  assign r_s   = $signed(64'(eff_pops_i));
  assign rm1_s = r_s - 64'sd1;
  assign nn_s  = $signed(64'(nn_q));
  assign ss_s  = $signed(64'(s2sum_q));
  assign rdd   = 33'((dd_q + 56'd8388608) >> 24);
  assign tot_w = 64'(sat32(64'(as_q) + 64'(sat32(b_q)) + 64'((hb_q + 32'sd1) >>> 1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= K_PB;
      stat_q      <= STAT_OK;
      for (int k = 0; k < MAX_POPS; k++) begin
        pop_dos_q[k] <= '0;
        pop_cnt_q[k] <= '0;
      end
      tot_dos_q   <= '0;
      tot_het_q   <= '0;
      tot_cnt_q   <= '0;
      idx_q       <= '0;
      low_q       <= 1'b0;
      zero_q      <= 1'b0;
      s2sum_q     <= '0;
      nn_q        <= '0;
      num_q       <= '0;
      den_q       <= '0;
      div_go_q    <= 1'b0;
      pb_q        <= '0;
      hb_q        <= '0;
      s2_q        <= '0;
      pq_q        <= '0;
      rs_q        <= '0;
      x_q         <= '0;
      inner_q     <= '0;
      qf_q        <= '0;
      as_q        <= '0;
      y_q         <= '0;
      tot_q       <= '0;
      fst_q       <= '0;
      d_q         <= '0;
      dd_q        <= '0;
      t_q         <= '0;
      ap_q        <= '0;
      b_q         <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      div_go_q    <= 1'b0;
      res_valid_q <= 1'b0;
      unique case (state_q)
        // accumulate one request per cycle while the queue is not empty
        S_IDLE: begin
          if (q_pop_o) begin
            if (acc_ok) begin
              pop_dos_q[rd_addr] <= DOS_W'(dos_rd + DOS_W'(q_entry_i.dos));
              pop_cnt_q[rd_addr] <= n_rd + CNT_W'(1);
              tot_dos_q          <= DOS_W'(tot_dos_q + DOS_W'(q_entry_i.dos));
              tot_het_q          <= HET_W'(tot_het_q + HET_W'(q_entry_i.het));
              tot_cnt_q          <= tot_cnt_q + CNT_W'(1);
            end
            if (q_entry_i.last) begin
              idx_q   <= '0;
              low_q   <= 1'b0;
              zero_q  <= 1'b0;
              s2sum_q <= '0;
              t_q     <= '0;
              state_q <= S_CHK;
            end
          end
        end
        // scan population counts
        S_CHK: begin
          if (n_rd < min_per_pop_i) low_q <= 1'b1;
          if (n_rd == '0) zero_q <= 1'b1;
          s2sum_q <= s2sum_q + SSW'(n_sq);
          if (last_idx) state_q <= S_CLS;
          else idx_q <= idx_q + IW'(1);
        end
        // status decision
        S_CLS: begin
          nn_q <= nn;
          if (low_q) begin
            stat_q  <= STAT_LOW_POP;
            state_q <= S_OUT;
          end else if (tot_cnt_q == '0) begin
            stat_q  <= STAT_DEGEN;
            state_q <= S_OUT;
          end else if (maf_fail) begin
            stat_q  <= STAT_LOW_MAF;
            state_q <= S_OUT;
          end else if (degen) begin
            stat_q  <= STAT_DEGEN;
            state_q <= S_OUT;
          end else begin
            step_q  <= K_PB;
            state_q <= S_PREP;
          end
        end
        // load divider operands
        S_PREP: begin
          div_go_q <= 1'b1;
          state_q  <= S_DIV;
          unique case (step_q)
            K_PB: begin
              num_q <= $signed(NUM_W'({tot_dos_q, 8'b0}));
              den_q <= $signed(DEN_W'(tot_cnt_q));
            end
            K_HB: begin
              num_q <= $signed(NUM_W'({tot_het_q, 9'b0}));
              den_q <= $signed(DEN_W'(tot_cnt_q));
            end
            K_PI: begin
              num_q <= $signed(NUM_W'({dos_rd, 8'b0}));
              den_q <= $signed(DEN_W'(n_rd));
            end
            K_S2: begin
              num_q <= $signed(64'(t_q)) * r_s;
              den_q <= DEN_W'(rm1_s * n_s);
            end
            K_RS: begin
              num_q <= 64'(s2_q) * rm1_s;
              den_q <= DEN_W'(r_s);
            end
            K_X: begin
              num_q <= 64'(x_q) * r_s;
              den_q <= DEN_W'(n_s - r_s);
            end
            K_Q: begin
              num_q <= (nn_s * rm1_s) <<< 24;
              den_q <= DEN_W'(r_s * (nn_s - ss_s));
            end
            K_Y: begin
              num_q <= 64'(hb_q) * (n_s + n_s - r_s);
              den_q <= DEN_W'(n_s <<< 2);
            end
            K_B: begin
              num_q <= 64'(y_q) * n_s;
              den_q <= DEN_W'(n_s - r_s);
            end
            K_F: begin
              num_q <= 64'(as_q) <<< 16;
              den_q <= DEN_W'(tot_q);
            end
            default: ;
          endcase
        end
        // wait on the divider
        S_DIV: begin
          if (div_done) state_q <= S_POST;
        end
        // use the quotient
        S_POST: begin
          state_q <= S_PREP;
          unique case (step_q)
            K_PB: begin
              pb_q   <= clamp_freq(quo);
              step_q <= K_HB;
            end
            K_HB: begin
              hb_q   <= clamp_freq(quo);
              idx_q  <= '0;
              step_q <= K_PI;
            end
            K_PI: begin
              d_q     <= 28'(clamp_freq(quo) - pb_q);
              state_q <= S_SQ;
            end
            K_S2: begin
              s2_q    <= sat32(quo);
              state_q <= S_PQ;
            end
            K_RS: begin
              rs_q   <= quo[31:0];
              x_q    <= sat32(64'(pq_q) - quo - 64'((hb_q + 32'sd2) >>> 2));
              step_q <= K_X;
            end
            K_X: begin
              inner_q <= sat32(64'(s2_q) - quo);
              step_q  <= K_Q;
            end
            K_Q: begin
              qf_q    <= sat32(quo);
              state_q <= S_A;
            end
            K_Y: begin
              y_q    <= sat32(64'(pq_q) - 64'(rs_q) - quo);
              step_q <= K_B;
            end
            K_B: begin
              b_q     <= quo;
              state_q <= S_TOT;
            end
            K_F: begin
              fst_q   <= sat32(quo);
              stat_q  <= STAT_OK;
              state_q <= S_OUT;
            end
            default: state_q <= S_OUT;
          endcase
        end
        // squared deviation of one population
        S_SQ: begin
          dd_q    <= d_q * d_q;
          state_q <= S_TACC;
        end
        // weight by population size and sum
        S_TACC: begin
          t_q     <= t_q + 48'(n_rd * rdd);
          state_q <= S_PREP;
          if (last_idx) begin
            step_q <= K_S2;
          end else begin
            idx_q  <= idx_q + IW'(1);
            step_q <= K_PI;
          end
        end
        // pbar times one minus pbar
        S_PQ: begin
          pq_q    <= 32'(rnd24(64'(pb_q) * (ONE_Q24 - 64'(pb_q))));
          step_q  <= K_RS;
          state_q <= S_PREP;
        end
        // component a
        S_A: begin
          ap_q    <= 64'(inner_q) * 64'(qf_q);
          state_q <= S_A2;
        end
        S_A2: begin
          as_q    <= sat32(rnd24(ap_q));
          step_q  <= K_Y;
          state_q <= S_PREP;
        end
        // total a+b+c
        S_TOT: begin
          tot_q <= tot_w[31:0];
          if (tot_w == 64'sd0) begin
            stat_q  <= STAT_DEGEN;
            state_q <= S_OUT;
          end else begin
            step_q  <= K_F;
            state_q <= S_PREP;
          end
        end
        // present result and clear the site
        S_OUT: begin
          res_valid_q    <= 1'b1;
          res_q.status   <= stat_q;
          if (stat_q == STAT_OK) begin
            res_q.within_component <= as_q;
            res_q.total_component  <= tot_q;
            res_q.fst_value        <= fst_q;
          end else begin
            res_q.within_component <= '0;
            res_q.total_component  <= '0;
            res_q.fst_value        <= '0;
          end
          for (int k = 0; k < MAX_POPS; k++) begin
            pop_dos_q[k] <= '0;
            pop_cnt_q[k] <= '0;
          end
          tot_dos_q <= '0;
          tot_het_q <= '0;
          tot_cnt_q <= '0;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* design/weir_cockerham_fst_site.sv */
// ----------------------------------------------------------------------------
// weir_cockerham_fst_site
// Per-site Weir-Cockerham Fst estimator over streamed genotype probabilities.
// ----------------------------------------------------------------------------
// Usage:
//   Individuals arrive on item_i, one request taken at each edge where start
//   is high and busy is low. Each carries three Q1.15 genotype probabilities,
//   a population index and a last-of-site mark.
//   While the site accumulates, one individual is taken every cycle; a
//   two-entry queue sits between intake and the accumulator.
//   The last individual starts the finish sequence: a scan of r population
//   counts, then, if the site passes the filters, up to r+9 rounded divisions
//   on one shared divider, each with operand load and quotient use, plus
//   two multiply steps for every population and a few at the end.
//   During it busy rises once the queue holds two further individuals.
//   The result (status, a, a+b+c, Fst) is on result_o for one cycle with
//   result_valid_o high; the receiver cannot stall, so it must take it then.
//   Registers are written on cfg_valid_i, cfg_ready_o always high; the user
//   must write only while the block is idle; it is not enforced. Reset loads
//   pop_count 2, min_per_pop 1, allele frequency 0, clears all accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module weir_cockerham_fst_site #(
  parameter int MAX_POPS        = 16,
  parameter int MAX_INDIVIDUALS = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire wcf_pkg::wcf_in_t                    item_i,
  output logic                                     result_valid_o,
  output wcf_pkg::wcf_out_t                        result_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [wcf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [wcf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import wcf_pkg::*;

  localparam int RW = $clog2(MAX_POPS + 1);

  logic [4:0]            pop_count_q;
  logic [CNT_W-1:0]      min_per_pop_q;
  logic [CFG_DATA_W-1:0] min_maf_q;
  logic [RW-1:0]         eff_pops;
  logic                  q_valid, q_pop;
  wcf_entry_t            q_entry;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_count_q   <= 5'd2;
      min_per_pop_q <= CNT_W'(1);
      min_maf_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_POP_COUNT:   pop_count_q   <= cfg_data_i[4:0];
        CFG_MIN_PER_POP: min_per_pop_q <= cfg_data_i[CNT_W-1:0];
        CFG_MIN_MAF:     min_maf_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective population count
  always_comb begin
    if (pop_count_q < 5'd2) eff_pops = RW'(2);
    else if (32'(pop_count_q) > 32'(MAX_POPS)) eff_pops = RW'(MAX_POPS);
    else eff_pops = RW'(pop_count_q);
  end

  wcf_front #(
    .MAX_POPS (MAX_POPS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .eff_pops_i (eff_pops),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  wcf_back #(
    .MAX_POPS        (MAX_POPS),
    .MAX_INDIVIDUALS (MAX_INDIVIDUALS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .eff_pops_i    (eff_pops),
    .min_per_pop_i (min_per_pop_q),
    .min_maf_i     (min_maf_q),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .res_valid_o   (result_valid_o),
    .res_o         (result_o)
  );

endmodule

`default_nettype wire

/* dv/weir_cockerham_fst_site_tb.sv */
// ----------------------------------------------------------------------------
// weir_cockerham_fst_site_tb
// Streams sites of individuals into the Fst estimator, predicts each site
// result with a bit-accurate software model and checks it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

// expected site results and the accumulator state that produces them
class wcf_site_scoreboard;
  localparam int NPOP = 16;
  localparam int NIND = 1024;
  localparam longint Q24 = 64'sd16777216;

  logic [4:0]  pop_count;
  logic [10:0] min_per_pop;
  logic [14:0] min_maf;
  logic [26:0] pop_dos[NPOP];
  logic [10:0] pop_cnt[NPOP];
  logic [26:0] tot_dos;
  logic [25:0] tot_het;
  logic [10:0] tot_cnt;
  wcf_pkg::wcf_out_t pending[$];
  int errors;

  function new();
    pop_count = 2;
    min_per_pop = 1;
    min_maf = 0;
    errors = 0;
    clear_sums();
  endfunction

  function void clear_sums();
    for (int i = 0; i < NPOP; i++) begin
      pop_dos[i] = '0;
      pop_cnt[i] = '0;
    end
    tot_dos = '0;
    tot_het = '0;
    tot_cnt = '0;
  endfunction

  function void set_reg(wcf_pkg::wcf_cfg_e idx, logic [14:0] val);
    case (idx)
      wcf_pkg::CFG_POP_COUNT:   pop_count = val[4:0];
      wcf_pkg::CFG_MIN_PER_POP: min_per_pop = val[10:0];
      wcf_pkg::CFG_MIN_MAF:     min_maf = val;
      default: ;
    endcase
  endfunction

  function int active_pops();
    if (pop_count < 2) return 2;
    if (pop_count > NPOP) return NPOP;
    return pop_count;
  endfunction

  // rounded division, ties away from zero
  function longint rdiv(longint num, longint den);
    longint q;
    if (den == 0) return 0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num >= 0) return (num + den / 2) / den;
    q = (-num + den / 2) / den;
    return -q;
  endfunction

  function longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint clampf(longint v);
    if (v < 0) return 0;
    if (v > 4 * Q24) return 4 * Q24;
    return v;
  endfunction

  // variance components and Fst over the accumulated site
  function wcf_pkg::wcf_out_t site_fst();
    wcf_pkg::wcf_out_t res;
    longint r, n_tot, a_s, tot_s, fst, two_n, lim, sq_sum, n, p, d, t;
    longint pb, hb, s2, pq, rs, x, inner, q, a, y, b, c;
    wcf_pkg::wcf_status_e st;
    r = active_pops();
    n_tot = tot_cnt;
    a_s = 0;
    tot_s = 0;
    fst = 0;
    st = wcf_pkg::STAT_OK;
    for (int i = 0; i < r; i++)
      if (pop_cnt[i] < min_per_pop) st = wcf_pkg::STAT_LOW_POP;
    if (st == wcf_pkg::STAT_OK && n_tot == 0) st = wcf_pkg::STAT_DEGEN;
    if (st == wcf_pkg::STAT_OK) begin
      two_n = 2 * n_tot;
      lim = two_n * longint'(min_maf);
      if (longint'(tot_dos) < lim || two_n * 32768 - longint'(tot_dos) < lim)
        st = wcf_pkg::STAT_LOW_MAF;
    end
    if (st == wcf_pkg::STAT_OK) begin
      sq_sum = 0;
      for (int i = 0; i < r; i++) begin
        n = pop_cnt[i];
        if (n == 0) st = wcf_pkg::STAT_DEGEN;
        sq_sum += n * n;
      end
      if (n_tot == r || n_tot * n_tot - sq_sum == 0) st = wcf_pkg::STAT_DEGEN;
      if (st == wcf_pkg::STAT_OK) begin
        pb = clampf(rdiv(longint'(tot_dos) * 256, n_tot));
        hb = clampf(rdiv(longint'(tot_het) * 512, n_tot));
        t = 0;
        for (int i = 0; i < r; i++) begin
          n = pop_cnt[i];
          p = clampf(rdiv(longint'(pop_dos[i]) * 256, n));
          d = p - pb;
          t += n * rdiv(d * d, Q24);
        end
        s2 = sat(rdiv(t * r, (r - 1) * n_tot));
        pq = rdiv(pb * (Q24 - pb), Q24);
        rs = rdiv(s2 * (r - 1), r);
        x = sat(pq - rs - rdiv(hb, 4));
        inner = sat(s2 - rdiv(x * r, n_tot - r));
        q = sat(rdiv(n_tot * n_tot * (r - 1) * Q24, r * (n_tot * n_tot - sq_sum)));
        a = rdiv(inner * q, Q24);
        y = sat(pq - rs - rdiv(hb * (2 * n_tot - r), 4 * n_tot));
        b = rdiv(y * n_tot, n_tot - r);
        c = rdiv(hb, 2);
        a_s = sat(a);
        tot_s = sat(a_s + sat(b) + c);
        if (tot_s == 0) st = wcf_pkg::STAT_DEGEN;
        else fst = sat(rdiv(a_s * 65536, tot_s));
      end
    end
    if (st != wcf_pkg::STAT_OK) begin
      a_s = 0;
      tot_s = 0;
      fst = 0;
    end
    res.status = st;
    res.within_component = a_s[31:0];
    res.total_component = tot_s[31:0];
    res.fst_value = fst[31:0];
    return res;
  endfunction

  // accepted individual: accumulate, and on the last one predict the site
  function void note_individual(wcf_pkg::wcf_in_t it);
    logic missing;
    logic [17:0] dos;
    missing = it.prob_ref == wcf_pkg::NA_CODE && it.prob_het == wcf_pkg::NA_CODE
              && it.prob_alt == wcf_pkg::NA_CODE;
    if (!missing && it.pop_index < active_pops() && tot_cnt < NIND) begin
      dos = 18'(it.prob_het) + 18'(it.prob_alt) * 2;
      pop_dos[it.pop_index] += 27'(dos);
      pop_cnt[it.pop_index] += 1;
      tot_dos += 27'(dos);
      tot_het += 26'(it.prob_het);
      tot_cnt += 1;
    end
    if (it.last_individual) begin
      pending.push_back(site_fst());
      clear_sums();
    end
  endfunction

  function void check_result(wcf_pkg::wcf_out_t got);
    wcf_pkg::wcf_out_t exp_r;
    if (pending.size() == 0) begin
      $error("unexpected site result status=%0d", got.status);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.status !== exp_r.status) begin
      $error("status exp %0d got %0d", exp_r.status, got.status);
      errors++;
    end
    if (got.within_component !== exp_r.within_component) begin
      $error("within_component exp %0d got %0d", exp_r.within_component,
             got.within_component);
      errors++;
    end
    if (got.total_component !== exp_r.total_component) begin
      $error("total_component exp %0d got %0d", exp_r.total_component,
             got.total_component);
      errors++;
    end
    if (got.fst_value !== exp_r.fst_value) begin
      $error("fst_value exp %0d got %0d", exp_r.fst_value, got.fst_value);
      errors++;
    end
  endfunction
endclass

module weir_cockerham_fst_site_tb;
  import wcf_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  wcf_in_t item_i;
  logic result_valid_o;
  wcf_out_t result_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  wcf_site_scoreboard sb;
  int sent;
  logic gaps_on;

  weir_cockerham_fst_site dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .result_valid_o(result_valid_o), .result_o(result_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(result_o);
  end

  // one request, held until accepted; a random gap before it
  task automatic send_individual(wcf_in_t it);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_individual(it);
    sent++;
    @(negedge clk_i);
  endtask

  // wait for every pending site result, then let the finish sequence settle
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(wcf_cfg_e idx, logic [14:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic wcf_in_t make_ind(int pops, logic last, int shape);
    wcf_in_t it;
    int pr, ph;
    case (shape)
      0: begin
        pr = $urandom_range(0, 32768);
        ph = $urandom_range(0, 32768 - pr);
        it.prob_ref = 16'(pr);
        it.prob_het = 16'(ph);
        it.prob_alt = 16'(32768 - pr - ph);
      end
      1: begin
        it.prob_ref = NA_CODE;
        it.prob_het = NA_CODE;
        it.prob_alt = NA_CODE;
      end
      default: begin
        it.prob_ref = 16'($urandom());
        it.prob_het = 16'($urandom());
        it.prob_alt = 16'($urandom());
      end
    endcase
    it.pop_index = (shape == 3) ? 4'($urandom()) : 4'($urandom_range(0, pops - 1));
    it.last_individual = last;
    return it;
  endfunction

  // one site of random individuals
  task automatic send_site(int pops, int len);
    int shape;
    for (int k = 0; k < len; k++) begin
      shape = $urandom_range(0, 19);
      shape = shape < 15 ? 0 : shape < 17 ? 1 : shape < 19 ? 2 : 3;
      send_individual(make_ind(pops, k == len - 1, shape));
    end
  endtask

  task automatic directed();
    wcf_in_t it;
    // extremes: all ref, all alt, all het, then max raw fields
    it = '{prob_ref: 16'd32768, prob_het: 16'd0, prob_alt: 16'd0, pop_index: 4'd0,
           last_individual: 1'b0};
    send_individual(it);
    it = '{prob_ref: 16'd0, prob_het: 16'd0, prob_alt: 16'd32768, pop_index: 4'd1,
           last_individual: 1'b0};
    send_individual(it);
    it = '{prob_ref: 16'd0, prob_het: 16'd32768, prob_alt: 16'd0, pop_index: 4'd0,
           last_individual: 1'b0};
    send_individual(it);
    it = '{prob_ref: 16'hffff, prob_het: 16'hffff, prob_alt: 16'hffff, pop_index: 4'd1,
           last_individual: 1'b0};
    send_individual(it);
    // population out of range, then missing individual ends the site
    it = '{prob_ref: 16'd0, prob_het: 16'd100, prob_alt: 16'd0, pop_index: 4'hf,
           last_individual: 1'b0};
    send_individual(it);
    it = '{prob_ref: NA_CODE, prob_het: NA_CODE, prob_alt: NA_CODE, pop_index: 4'd0,
           last_individual: 1'b1};
    send_individual(it);
    // empty site: degenerate or low population
    it = '{prob_ref: NA_CODE, prob_het: NA_CODE, prob_alt: NA_CODE, pop_index: 4'd1,
           last_individual: 1'b1};
    send_individual(it);
    // one per population: N equals r
    it = '{prob_ref: 16'd0, prob_het: 16'd1000, prob_alt: 16'd2000, pop_index: 4'd0,
           last_individual: 1'b0};
    send_individual(it);
    it.pop_index = 4'd1;
    it.last_individual = 1'b1;
    send_individual(it);
    // random sites against a frequency filter, then with no population minimum
    drain();
    write_reg(CFG_MIN_MAF, 15'd16384);
    send_site(2, 6);
    drain();
    write_reg(CFG_MIN_MAF, 15'd0);
    write_reg(CFG_MIN_PER_POP, 15'd0);
    send_site(2, 5);
    drain();
  endtask

  initial begin
    int pops, len, phase;
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_POP_COUNT;
    cfg_data_i = '0;
    sent = 0;
    gaps_on = 1'b1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    directed();
    phase = 0;
    while (sent < 950) begin
      // new settings between phases, extremes included
      case (phase % 5)
        0: pops = 16;
        1: pops = 2;
        2: pops = $urandom_range(0, 1);
        3: pops = $urandom_range(17, 31);
        default: pops = $urandom_range(3, 15);
      endcase
      write_reg(CFG_POP_COUNT, 15'(pops));
      pops = pops < 2 ? 2 : pops > 16 ? 16 : pops;
      write_reg(CFG_MIN_PER_POP, phase % 7 == 6 ? 15'd1024 : 15'($urandom_range(0, 2)));
      write_reg(CFG_MIN_MAF, phase % 6 == 5 ? 15'($urandom()) :
                15'($urandom_range(0, 2000)));
      gaps_on = (phase % 4) != 3;
      for (int s = 0; s < 8 && sent < 950; s++) begin
        len = $urandom_range(pops + 1, 3 * pops + 4);
        send_site(pops, len);
      end
      drain();
      phase++;
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

`default_nettype wire
